@@ rtl/mobius_transform_unit_top_defines.svh @@
// Assertion macros for the Mobius transformation unit.
`ifndef MOBIUS_TRANSFORM_UNIT_TOP_DEFINES_SVH
`define MOBIUS_TRANSFORM_UNIT_TOP_DEFINES_SVH
// Assert a property on the rising clock, disabled in reset.
`define MTU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Assert a property with no reset disable.
`define MTU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`endif

@@ rtl/mtu_pkg.sv @@
// Shared types, status codes and config register indices of the Mobius unit.
package mtu_pkg;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned CfgIdxWidth = 2;

  typedef enum logic [StatusWidth-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_DIV0 = 2'd1,
    STATUS_SAT  = 2'd2
  } status_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_COEF_A = 2'd0,
    REG_COEF_B = 2'd1,
    REG_COEF_C = 2'd2,
    REG_COEF_D = 2'd3
  } reg_idx_e;
endpackage

@@ rtl/mtu_stream_if.sv @@
// Valid/ready stream interface carrying a generic payload.
interface mtu_stream_if #(
  parameter int unsigned PayloadWidth = 64
);
  logic                    valid;
  logic                    ready;
  logic [PayloadWidth-1:0] payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/mtu_fmul.sv @@
// Registered fixed-point multiplier: floor shift, saturate, flag.
module mtu_fmul #(
  parameter int unsigned DataWidth = 32,
  parameter int unsigned FracBits  = 16
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [DataWidth-1:0] a_i,
  input  logic signed [DataWidth-1:0] b_i,
  output logic signed [DataWidth-1:0] p_o,
  output logic                        sat_o
);
  localparam int unsigned PW = 2 * DataWidth;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] shifted;
  logic signed [DataWidth-1:0] vmax, vmin;
  logic signed [DataWidth-1:0] p_d;
  logic sat_d;

  always_comb begin
    vmax = {1'b0, {(DataWidth-1){1'b1}}};
    vmin = {1'b1, {(DataWidth-1){1'b0}}};
    prod = PW'(a_i) * PW'(b_i);
    prod = $signed({{DataWidth{a_i[DataWidth-1]}}, a_i}) *
           $signed({{DataWidth{b_i[DataWidth-1]}}, b_i});
    shifted = prod >>> FracBits;
    sat_d = 1'b0;
    p_d = shifted[DataWidth-1:0];
    if (shifted > PW'(vmax)) begin
      p_d = vmax;
      sat_d = 1'b1;
    end else if (shifted < PW'(vmin)) begin
      p_d = vmin;
      sat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_o   <= p_d;
      sat_o <= sat_d;
    end
  end
endmodule

@@ rtl/mtu_fadd.sv @@
// Saturating adder/subtractor, combinational.
module mtu_fadd #(
  parameter int unsigned DataWidth = 32
) (
  input  logic signed [DataWidth-1:0] a_i,
  input  logic signed [DataWidth-1:0] b_i,
  input  logic                        sub_i,
  output logic signed [DataWidth-1:0] s_o,
  output logic                        sat_o
);
  logic signed [DataWidth:0] sum;
  always_comb begin
    sum = sub_i ? ($signed({a_i[DataWidth-1], a_i}) - $signed({b_i[DataWidth-1], b_i}))
                : ($signed({a_i[DataWidth-1], a_i}) + $signed({b_i[DataWidth-1], b_i}));
    sat_o = sum[DataWidth] != sum[DataWidth-1];
    if (!sat_o) s_o = sum[DataWidth-1:0];
    else if (sum[DataWidth]) s_o = {1'b1, {(DataWidth-1){1'b0}}};
    else s_o = {1'b0, {(DataWidth-1){1'b1}}};
  end
endmodule

@@ rtl/mtu_div_stage.sv @@
// One restoring-division step stage for the pipelined quotient unit.
module mtu_div_stage #(
  parameter int unsigned DenWidth = 32,
  parameter int unsigned SideWidth = 8
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [DenWidth:0]    rem_i,
  input  logic                 bit_i,
  input  logic [DenWidth-1:0]  den_i,
  input  logic [SideWidth-1:0] side_i,
  output logic [DenWidth:0]    rem_o,
  output logic                 q_o,
  output logic [DenWidth-1:0]  den_o,
  output logic [SideWidth-1:0] side_o
);
  logic [DenWidth+1:0] shifted;
  logic [DenWidth+1:0] diff;
  always_comb begin
    shifted = {rem_i, bit_i};
    diff = shifted - {2'b00, den_i};
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_o    <= !diff[DenWidth+1];
      rem_o  <= diff[DenWidth+1] ? shifted[DenWidth:0] : diff[DenWidth:0];
      den_o  <= den_i;
      side_o <= side_i;
    end
  end
endmodule

@@ rtl/mobius_transform_unit_top.sv @@
// Top level of the pipelined Mobius transformation unit.
// Pipeline, input transfer to result valid: two multiply stages, two sum stages,
//   magnitude and dividend loads, one quotient bit per stage, output register.
// Throughput: one point per cycle; a full output register stalls all stages.
// Reset: rst_ni clears all valid bits and loads a=d=1.0, b=c=0.
// Payload registers are not reset.
`include "mobius_transform_unit_top_defines.svh"
module mobius_transform_unit_top
  import mtu_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [DATA_WIDTH-1:0] cfg_data_i,
  mtu_stream_if.sink            in_if,
  mtu_stream_if.source          out_if
);
  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned QW = DW + FRAC_BITS;   // dividend bits
  localparam int unsigned NS = 6;                // stages before the divider
  localparam int unsigned SW = 2;                // side info: neg flag + status flag

  typedef logic signed [DW-1:0] word_t;

  // Configuration registers.
  word_t coef_a_q, coef_b_q, coef_c_q, coef_d_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q <= word_t'(1) <<< FRAC_BITS;
      coef_b_q <= '0;
      coef_c_q <= '0;
      coef_d_q <= word_t'(1) <<< FRAC_BITS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_COEF_A: coef_a_q <= cfg_data_i;
        REG_COEF_B: coef_b_q <= cfg_data_i;
        REG_COEF_C: coef_c_q <= cfg_data_i;
        REG_COEF_D: coef_d_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Global stall: every stage advances unless the output holds an untaken result.
  logic adv;
  logic out_valid_q;
  assign adv = !out_valid_q || out_if.ready;
  assign in_if.ready = adv;

  // One valid bit per register stage ahead of the output register.
  localparam int unsigned TotS = NS + QW;
  logic [TotS-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[TotS-2:0], in_if.valid};
  end

  word_t re_in, im_in;
  assign re_in = in_if.payload[DW-1:0];
  assign im_in = in_if.payload[2*DW-1:DW];

  // Stage 1: c*re, c*im, a*re, a*im, a*d, b*c.
  word_t cr1, ci1, ar1, ai1, ad1, bc1;
  logic  s_cr1, s_ci1, s_ar1, s_ai1, s_ad1, s_bc1;
  word_t im1, b1, d1;
  mtu_fmul #(DW, FRAC_BITS) u_m_cr (clk_i, adv, coef_c_q, re_in, cr1, s_cr1);
  mtu_fmul #(DW, FRAC_BITS) u_m_ci (clk_i, adv, coef_c_q, im_in, ci1, s_ci1);
  mtu_fmul #(DW, FRAC_BITS) u_m_ar (clk_i, adv, coef_a_q, re_in, ar1, s_ar1);
  mtu_fmul #(DW, FRAC_BITS) u_m_ai (clk_i, adv, coef_a_q, im_in, ai1, s_ai1);
  mtu_fmul #(DW, FRAC_BITS) u_m_ad (clk_i, adv, coef_a_q, coef_d_q, ad1, s_ad1);
  mtu_fmul #(DW, FRAC_BITS) u_m_bc (clk_i, adv, coef_b_q, coef_c_q, bc1, s_bc1);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      im1 <= im_in;
      b1  <= coef_b_q;
      d1  <= coef_d_q;
    end
  end

  // Stage 2: u = c*re + d, w = a*re + b, k = a*d - b*c.
  word_t u_c, w_c, k_c;
  logic  s_u, s_w, s_k;
  mtu_fadd #(DW) u_a_u (cr1, d1, 1'b0, u_c, s_u);
  mtu_fadd #(DW) u_a_w (ar1, b1, 1'b0, w_c, s_w);
  mtu_fadd #(DW) u_a_k (ad1, bc1, 1'b1, k_c, s_k);
  word_t u2, w2, k2, v2, p2, im2;
  logic  sat2;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      u2 <= u_c; w2 <= w_c; k2 <= k_c; v2 <= ci1; p2 <= ai1; im2 <= im1;
      sat2 <= s_cr1 | s_ci1 | s_ar1 | s_ai1 | s_ad1 | s_bc1 | s_u | s_w | s_k;
    end
  end

  // Stage 3: products u*u, v*v, w*u, p*v, k*im.
  word_t uu3, vv3, wu3, pv3, ni3;
  logic  s_uu, s_vv, s_wu, s_pv, s_ni, sat3;
  mtu_fmul #(DW, FRAC_BITS) u_m_uu (clk_i, adv, u2, u2, uu3, s_uu);
  mtu_fmul #(DW, FRAC_BITS) u_m_vv (clk_i, adv, v2, v2, vv3, s_vv);
  mtu_fmul #(DW, FRAC_BITS) u_m_wu (clk_i, adv, w2, u2, wu3, s_wu);
  mtu_fmul #(DW, FRAC_BITS) u_m_pv (clk_i, adv, p2, v2, pv3, s_pv);
  mtu_fmul #(DW, FRAC_BITS) u_m_ni (clk_i, adv, k2, im2, ni3, s_ni);
  always_ff @(posedge clk_i) begin
    if (adv) sat3 <= sat2;
  end

  // Stage 4: den and real numerator.
  word_t den_c, nre_c;
  logic  s_den, s_nre;
  mtu_fadd #(DW) u_a_den (uu3, vv3, 1'b0, den_c, s_den);
  mtu_fadd #(DW) u_a_nre (wu3, pv3, 1'b0, nre_c, s_nre);
  word_t den4, nre4, nim4;
  logic  sat4;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      den4 <= den_c; nre4 <= nre_c; nim4 <= ni3;
      sat4 <= sat3 | s_uu | s_vv | s_wu | s_pv | s_ni | s_den | s_nre;
    end
  end

  // Stage 5: magnitudes and divide-by-zero check.
  logic [DW-1:0] mre5, mim5, den5;
  logic nre_neg5, nim_neg5, zero5, sat5;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      nre_neg5 <= nre4[DW-1];
      nim_neg5 <= nim4[DW-1];
      mre5 <= nre4[DW-1] ? DW'(-nre4) : DW'(nre4);
      mim5 <= nim4[DW-1] ? DW'(-nim4) : DW'(nim4);
      zero5 <= (den4 <= 0);
      den5 <= (den4 <= 0) ? DW'(1) : DW'(den4);
      sat5 <= sat4;
    end
  end

  // Stages 6..: two restoring dividers in lockstep, one quotient bit per stage.
  logic [QW-1:0] dvd_re6, dvd_im6;
  logic [DW-1:0] den6;
  logic nre_neg6, nim_neg6, zero6, sat6;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dvd_re6 <= {mre5, {FRAC_BITS{1'b0}}};
      dvd_im6 <= {mim5, {FRAC_BITS{1'b0}}};
      den6 <= den5; nre_neg6 <= nre_neg5; nim_neg6 <= nim_neg5;
      zero6 <= zero5; sat6 <= sat5;
    end
  end

  logic [DW:0]   rem_re [QW+1], rem_im [QW+1];
  logic [DW-1:0] den_s  [QW+1], den_t [QW+1];
  logic [SW-1:0] side_re[QW+1], side_im[QW+1];
  logic [QW-1:0] dvd_re_s[QW+1], dvd_im_s[QW+1];
  logic [QW:0]   qb_re, qb_im;

  assign rem_re[0] = '0;
  assign rem_im[0] = '0;
  assign den_s[0] = den6;
  assign den_t[0] = den6;
  assign side_re[0] = {zero6, nre_neg6};
  assign side_im[0] = {sat6, nim_neg6};
  assign dvd_re_s[0] = dvd_re6;
  assign dvd_im_s[0] = dvd_im6;
  assign qb_re[0] = 1'b0;
  assign qb_im[0] = 1'b0;

  for (genvar g = 0; g < QW; g++) begin : g_div
    mtu_div_stage #(DW, SW) u_re (clk_i, adv, rem_re[g], dvd_re_s[g][QW-1-g], den_s[g],
      side_re[g], rem_re[g+1], qb_re[g+1], den_s[g+1], side_re[g+1]);
    mtu_div_stage #(DW, SW) u_im (clk_i, adv, rem_im[g], dvd_im_s[g][QW-1-g], den_t[g],
      side_im[g], rem_im[g+1], qb_im[g+1], den_t[g+1], side_im[g+1]);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dvd_re_s[g+1] <= dvd_re_s[g];
        dvd_im_s[g+1] <= dvd_im_s[g];
      end
    end
  end

  // Quotient accumulation: shift-register per stage built from qb outputs.
  logic [QW-1:0] qacc_re [QW+1], qacc_im [QW+1];
  assign qacc_re[0] = '0;
  assign qacc_im[0] = '0;
  for (genvar g = 1; g <= QW; g++) begin : g_q
    if (g < QW) begin : g_mid
      always_ff @(posedge clk_i) begin
        if (adv) begin
          qacc_re[g] <= {qacc_re[g-1][QW-2:0], qb_re[g]};
          qacc_im[g] <= {qacc_im[g-1][QW-2:0], qb_im[g]};
        end
      end
    end else begin : g_last
      assign qacc_re[g] = {qacc_re[g-1][QW-2:0], qb_re[g]};
      assign qacc_im[g] = {qacc_im[g-1][QW-2:0], qb_im[g]};
    end
  end

  // Final: saturate magnitudes, apply signs, pick status.
  logic [QW-1:0] lim_re, lim_im;
  logic ovf_re, ovf_im, zero_f, sat_f;
  word_t img_re_d, img_im_d;
  status_e st_d;
  always_comb begin
    zero_f = side_re[QW][1];
    sat_f  = side_im[QW][1];
    lim_re = QW'({1'b0, {(DW-1){1'b1}}}) + QW'(side_re[QW][0]);
    lim_im = QW'({1'b0, {(DW-1){1'b1}}}) + QW'(side_im[QW][0]);
    ovf_re = qacc_re[QW] > lim_re;
    ovf_im = qacc_im[QW] > lim_im;
    if (ovf_re) img_re_d = side_re[QW][0] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    else img_re_d = side_re[QW][0] ? -word_t'(qacc_re[QW][DW-1:0])
                                   : word_t'(qacc_re[QW][DW-1:0]);
    if (ovf_im) img_im_d = side_im[QW][0] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    else img_im_d = side_im[QW][0] ? -word_t'(qacc_im[QW][DW-1:0])
                                   : word_t'(qacc_im[QW][DW-1:0]);
    if (zero_f) begin
      img_re_d = '0;
      img_im_d = '0;
      st_d = STATUS_DIV0;
    end else if (sat_f || ovf_re || ovf_im) begin
      st_d = STATUS_SAT;
    end else begin
      st_d = STATUS_OK;
    end
  end

  // Output register.
  logic [2*DW+StatusWidth-1:0] out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (adv) out_valid_q <= vld_q[TotS-1];
  end
  always_ff @(posedge clk_i) begin
    if (adv) out_q <= {st_d, img_im_d, img_re_d};
  end
  assign out_if.valid = out_valid_q;
  assign out_if.payload = out_q;

  // Unused bookkeeping copies.
  logic unused_q;
  assign unused_q = ^{rem_re[QW], rem_im[QW], den_t[QW], den_s[QW],
                      dvd_re_s[QW], dvd_im_s[QW], qb_re[0], qb_im[0]};

  `MTU_ASSERT(a_stall_holds, out_valid_q && !out_if.ready |=> out_valid_q && $stable(out_q),
    "result changed while stalled")
  `MTU_ASSERT(a_div0_zero, out_valid_q && out_q[2*DW+StatusWidth-1 -: StatusWidth] == STATUS_DIV0
    |-> out_q[2*DW-1:0] == '0, "zero-denominator result not cleared")
  `MTU_ASSERT_ALWAYS(a_ready_adv, in_if.ready == (!out_valid_q || out_if.ready),
    "input ready does not follow output stall")
endmodule
